// ===== design/blpg_pkg.sv =====
// Shared constants for the Bresenham line pixel generator.
package blpg_pkg;

  // Coordinate width of the endpoint fields (two's complement)
  localparam int COORD_BITS = 11;

  // Default screen geometry
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 200;

  // Result field widths
  localparam int OFFSET_BITS = 16;
  localparam int PIX_X_BITS  = 9;
  localparam int PIX_Y_BITS  = 8;
  localparam int COLOR_BITS  = 8;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

endpackage

// ===== design/bresenham_line_pixel_generator_core.sv =====
// Bresenham line pixel generator: line setup, stepping, clamping and offset output.
//
// Load a line with func=0 (endpoints and color); the first pixel comes back
// in the next cycle. Each func=1 transfer advances one Bresenham step in any
// octant and returns the next pixel; a step with no active line returns
// nothing. Pixels are clamped to the screen and returned as column, row and
// linear offset row*SCREEN_WIDTH+column (low 16 bits), with is_last set on
// the end point, after which the line is no longer active. Throughput is one
// item per clock while out_ready is high; the step adders, the clamp and the
// single constant multiply for the offset sit between the line state and the
// result register. The result register frees up in the cycle it is taken, so
// in_ready stays high while out_ready is high.
module bresenham_line_pixel_generator_core #(
  parameter int SCREEN_WIDTH  = blpg_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = blpg_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic signed [blpg_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [blpg_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [blpg_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [blpg_pkg::COORD_BITS-1:0] end_y,
  input  logic [blpg_pkg::COLOR_BITS-1:0]        pen_color,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [blpg_pkg::OFFSET_BITS-1:0]       pixel_offset,
  output logic [blpg_pkg::PIX_X_BITS-1:0]        pixel_x,
  output logic [blpg_pkg::PIX_Y_BITS-1:0]        pixel_y,
  output logic [blpg_pkg::COLOR_BITS-1:0]        pixel_color,
  output logic                                  is_last
);
  import blpg_pkg::*;

  localparam int CB = COORD_BITS;
  // Clamp limits and multiplier constant, wide enough to hold the full range
  localparam logic [CB-1:0] W_LIM  = CB'(SCREEN_WIDTH);
  localparam logic [CB-1:0] H_LIM  = CB'(SCREEN_HEIGHT);
  localparam logic [CB-2:0] W_MAX  = (CB-1)'(SCREEN_WIDTH - 1);
  localparam logic [CB-2:0] H_MAX  = (CB-1)'(SCREEN_HEIGHT - 1);
  localparam int            PROD_BITS = 2 * CB - 1;

  // Line state
  logic signed [CB-1:0] cur_x, cur_y, goal_x, goal_y;
  logic        [CB:0]   span_x;
  logic signed [CB+1:0] neg_span_y;
  logic                 dir_x_neg, dir_y_neg;
  logic signed [CB+2:0] error_acc;
  logic [COLOR_BITS-1:0] line_color;
  logic                 line_active;

  logic signed [CB-1:0] cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  logic        [CB:0]   span_x_next;
  logic signed [CB+1:0] neg_span_y_next;
  logic                 dir_x_neg_next, dir_y_neg_next;
  logic signed [CB+2:0] error_acc_next;
  logic [COLOR_BITS-1:0] line_color_next;
  logic                 line_active_next;

  logic                 in_fire, emit;
  logic signed [CB:0]   dx, dy;
  logic signed [CB+3:0] e2, err_sum;
  logic                 step_x, step_y, last;
  logic [CB-2:0]        px_full, py_full;
  logic [PROD_BITS-1:0] row_base;
  logic [PROD_BITS-1:0] offset_full;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Load setup and one Bresenham step
  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    goal_x_next      = goal_x;
    goal_y_next      = goal_y;
    span_x_next      = span_x;
    neg_span_y_next  = neg_span_y;
    dir_x_neg_next   = dir_x_neg;
    dir_y_neg_next   = dir_y_neg;
    error_acc_next   = error_acc;
    line_color_next  = line_color;
    line_active_next = line_active;
    emit             = 1'b0;

    dx      = (CB+1)'(end_x) - (CB+1)'(start_x);
    dy      = (CB+1)'(end_y) - (CB+1)'(start_y);
    e2      = {error_acc, 1'b0};
    step_x  = e2 > (CB+4)'(neg_span_y);
    step_y  = e2 < $signed({3'b000, span_x});
    err_sum = (CB+4)'(error_acc)
            + (step_x ? (CB+4)'(neg_span_y) : '0)
            + (step_y ? $signed({3'b000, span_x}) : '0);

    if (in_fire) begin
      if (func == FUNC_LOAD) begin
        span_x_next      = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
        neg_span_y_next  = dy[CB] ? (CB+2)'(dy) : -(CB+2)'(dy);
        dir_x_neg_next   = !(start_x < end_x);
        dir_y_neg_next   = !(start_y < end_y);
        error_acc_next   = $signed({2'b00, span_x_next}) + (CB+3)'(neg_span_y_next);
        cur_x_next       = start_x;
        cur_y_next       = start_y;
        goal_x_next      = end_x;
        goal_y_next      = end_y;
        line_color_next  = pen_color;
        emit             = 1'b1;
      end else if (line_active) begin
        error_acc_next = err_sum[CB+2:0];
        if (step_x) cur_x_next = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
        if (step_y) cur_y_next = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        emit = 1'b1;
      end
    end

    last = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
    if (emit) line_active_next = !last;
  end

  // Clamp to the screen and form the linear offset
  always_comb begin
    if (cur_x_next[CB-1])                   px_full = '0;
    else if ({1'b0, cur_x_next[CB-2:0]} >= W_LIM) px_full = W_MAX;
    else                                    px_full = cur_x_next[CB-2:0];

    if (cur_y_next[CB-1])                   py_full = '0;
    else if ({1'b0, cur_y_next[CB-2:0]} >= H_LIM) py_full = H_MAX;
    else                                    py_full = cur_y_next[CB-2:0];

    row_base    = PROD_BITS'(py_full) * PROD_BITS'(W_LIM);
    offset_full = row_base + PROD_BITS'(px_full);
  end

  // Line state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
      span_x      <= '0;
      neg_span_y  <= '0;
      dir_x_neg   <= 1'b0;
      dir_y_neg   <= 1'b0;
      error_acc   <= '0;
      line_color  <= '0;
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      goal_x      <= goal_x_next;
      goal_y      <= goal_y_next;
      span_x      <= span_x_next;
      neg_span_y  <= neg_span_y_next;
      dir_x_neg   <= dir_x_neg_next;
      dir_y_neg   <= dir_y_neg_next;
      error_acc   <= error_acc_next;
      line_color  <= line_color_next;
      line_active <= line_active_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_offset <= offset_full[OFFSET_BITS-1:0];
      pixel_x      <= px_full[PIX_X_BITS-1:0];
      pixel_y      <= py_full[PIX_Y_BITS-1:0];
      pixel_color  <= line_color_next;
      is_last      <= last;
    end
  end

`ifndef SYNTH
  // Reset leaves no pending result and no active line
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid && !line_active)
    else $error("state not cleared by reset");

  // Every load transfer yields a result in the next cycle
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func == FUNC_LOAD) |=> out_valid)
    else $error("load transfer gave no pixel");

  // A step with no active line gives nothing new
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func == FUNC_STEP && !line_active && out_ready) |=> !out_valid)
    else $error("step without an active line gave a pixel");

  // Once the end point is shown the line is finished
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_last) |-> !line_active)
    else $error("line still active after its end point");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the Bresenham line pixel generator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import blpg_pkg::*;

  localparam int SCR_W = DEF_SCREEN_WIDTH;
  localparam int SCR_H = DEF_SCREEN_HEIGHT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_TAIL = 100;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One pen command as driven on the input channel
  typedef struct {
    logic                  func;
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic [COLOR_BITS-1:0] color;
  } pen_cmd_t;

  // One plotted pixel as seen on the output channel
  typedef struct {
    logic [OFFSET_BITS-1:0] offset;
    logic [PIX_X_BITS-1:0]  x;
    logic [PIX_Y_BITS-1:0]  y;
    logic [COLOR_BITS-1:0]  color;
    logic                   last;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func = FUNC_LOAD;
  coord_t                 start_x = '0;
  coord_t                 start_y = '0;
  coord_t                 end_x = '0;
  coord_t                 end_y = '0;
  logic [COLOR_BITS-1:0]  pen_color = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OFFSET_BITS-1:0] pixel_offset;
  logic [PIX_X_BITS-1:0]  pixel_x;
  logic [PIX_Y_BITS-1:0]  pixel_y;
  logic [COLOR_BITS-1:0]  pixel_color;
  logic                   is_last;

  bresenham_line_pixel_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .pen_color    (pen_color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_offset (pixel_offset),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .is_last      (is_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pen_cmd_t pending_cmds[$];
  pixel_t   expected_pixels[$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       in_took = 1'b0;
  bit       calm = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;

  // Line tracer state, mirrors the block's registers
  coord_t                cur_x, cur_y, goal_x, goal_y;
  logic [11:0]           span_x;
  logic signed [12:0]    neg_span_y;
  logic                  dir_x_neg, dir_y_neg;
  logic signed [13:0]    error_acc;
  logic [COLOR_BITS-1:0] line_color;
  logic                  line_active;

  task automatic flag_error(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int clamp_axis(input int v, input int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  // Queue the pixel at the current point; the end point closes the line
  task automatic plot_current();
    pixel_t pix;
    int     px;
    int     py;
    px = clamp_axis(int'(cur_x), SCR_W);
    py = clamp_axis(int'(cur_y), SCR_H);
    pix.offset = OFFSET_BITS'(py * SCR_W + px);
    pix.x      = PIX_X_BITS'(px);
    pix.y      = PIX_Y_BITS'(py);
    pix.color  = line_color;
    pix.last   = (cur_x == goal_x) && (cur_y == goal_y);
    if (pix.last)
      line_active = 1'b0;
    expected_pixels.push_back(pix);
  endtask

  // Advance the tracer by one accepted command
  task automatic trace_line(input pen_cmd_t cmd);
    int x0, y0, x1, y1, dx, dy;
    int err, e2, sx, nsy, cx, cy;
    if (cmd.func == FUNC_LOAD) begin
      x0 = cmd.sx;
      y0 = cmd.sy;
      x1 = cmd.ex;
      y1 = cmd.ey;
      dx = x1 - x0;
      dy = y1 - y0;
      span_x      = 12'(dx < 0 ? -dx : dx);
      neg_span_y  = 13'(dy < 0 ? dy : -dy);
      dir_x_neg   = !(x0 < x1);
      dir_y_neg   = !(y0 < y1);
      error_acc   = 14'((dx < 0 ? -dx : dx) + (dy < 0 ? dy : -dy));
      cur_x       = cmd.sx;
      cur_y       = cmd.sy;
      goal_x      = cmd.ex;
      goal_y      = cmd.ey;
      line_color  = cmd.color;
      line_active = 1'b1;
      plot_current();
    end else if (line_active) begin
      err = error_acc;
      sx  = span_x;
      nsy = neg_span_y;
      cx  = cur_x;
      cy  = cur_y;
      e2  = 2 * err;
      if (e2 > nsy) begin
        err += nsy;
        cx  += dir_x_neg ? -1 : 1;
      end
      if (e2 < sx) begin
        err += sx;
        cy  += dir_y_neg ? -1 : 1;
      end
      error_acc = 14'(err);
      cur_x     = COORD_BITS'(cx);
      cur_y     = COORD_BITS'(cy);
      plot_current();
    end
  endtask

  function automatic int clip_coord(input int v);
    if (v < -1024) return -1024;
    if (v > 1023) return 1023;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  task automatic push_cmd(input logic f, input int sx, input int sy, input int ex,
                          input int ey, input int color);
    pen_cmd_t cmd;
    cmd.func  = f;
    cmd.sx    = COORD_BITS'(sx);
    cmd.sy    = COORD_BITS'(sy);
    cmd.ex    = COORD_BITS'(ex);
    cmd.ey    = COORD_BITS'(ey);
    cmd.color = COLOR_BITS'(color);
    pending_cmds.push_back(cmd);
  endtask

  // Step commands carry junk endpoint fields, which the block must ignore
  task automatic push_steps(input int n);
    for (int i = 0; i < n; i++)
      push_cmd(FUNC_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
               $urandom_range(0, 255));
  endtask

  task automatic push_line(input int x0, input int y0, input int x1, input int y1,
                           input int color, input int nsteps);
    push_cmd(FUNC_LOAD, x0, y0, x1, y1, color);
    push_steps(nsteps);
  endtask

  // Stimulus: directed corner cases, then random lines
  initial begin
    int kind, reach, x0, y0, x1, y1, len, nsteps, extra, counted;
    // step before any line, full-screen diagonals dropped by reloads
    push_steps(1);
    push_line(-1024, -1024, 1023, 1023, 8'hFF, 1);
    push_line(-1024, 1023, 1023, -1024, 8'h00, 1);
    // single-point line, then a step with nothing left
    push_line(7, 7, 7, 7, 8'hA5, 1);
    // crosses the right and bottom edges into the clamp
    push_line(318, 198, 321, 201, 8'h3C, 4);
    // negative coordinates, steep, x decreasing
    push_line(1, -2, -1, 1, 8'h81, 3);
    // vertical and horizontal-leftward lines
    push_line(5, 5, 5, 8, 8'h5A, 3);
    push_line(6, 0, 4, 0, 8'hC3, 2);

    counted = 0;
    while (counted < 850) begin
      kind  = $urandom_range(0, 99);
      reach = 12;
      if (kind < 65 || (kind >= 85 && kind < 95)) begin
        x0 = int'($urandom_range(0, SCR_W + 40)) - 20;
        y0 = int'($urandom_range(0, SCR_H + 40)) - 20;
        if (kind >= 85) reach = 60;
      end else begin
        x0 = any_coord();
        y0 = any_coord();
      end
      if (kind >= 95) begin
        x1 = any_coord();
        y1 = any_coord();
      end else begin
        x1 = clip_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
        y1 = clip_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
      end
      len = (x1 > x0 ? x1 - x0 : x0 - x1);
      if ((y1 > y0 ? y1 - y0 : y0 - y1) > len)
        len = (y1 > y0 ? y1 - y0 : y0 - y1);
      nsteps = len;
      extra  = 0;
      case ($urandom_range(0, 9))
        0: nsteps = $urandom_range(0, len);
        1: extra = $urandom_range(1, 3);
        default: ;
      endcase
      if (kind >= 95 && nsteps > 20)
        nsteps = $urandom_range(0, 20);
      push_line(x0, y0, x1, y1, $urandom_range(0, 255), nsteps + extra);
      counted += 1 + nsteps;
      if ($urandom_range(0, 19) == 0)
        push_steps(1);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d pixels never arrived", expected_pixels.size()));
    if (error_count == 0)
      $display("bresenham_line_pixel_generator_core verification clean");
    else
      $display("bresenham_line_pixel_generator_core verification failed");
    $finish;
  end

  // Input driver: holds each command until its transfer, idles in bursts
  always @(negedge clk) begin
    calm = pending_cmds.size() < CALM_TAIL;
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 9);
      end else begin
        pen_cmd_t cmd;
        cmd = pending_cmds.pop_front();
        in_valid  <= 1'b1;
        func      <= cmd.func;
        start_x   <= cmd.sx;
        start_y   <= cmd.sy;
        end_x     <= cmd.ex;
        end_y     <= cmd.ey;
        pen_color <= cmd.color;
      end
    end
  end

  // Output back-pressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      out_gap = $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check delivered pixels, then predict from accepted commands
  always @(posedge clk) begin
    pen_cmd_t cmd;
    pixel_t   want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("bresenham_line_pixel_generator_core verification failed");
      $finish;
    end
    if (rst) begin
      in_took = 1'b0;
      cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
      span_x = '0; neg_span_y = '0; error_acc = '0;
      dir_x_neg = 1'b0; dir_y_neg = 1'b0;
      line_color = '0; line_active = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_offset !== want.offset)
            flag_error($sformatf("offset %0d, want %0d", pixel_offset, want.offset));
          if (pixel_x !== want.x)
            flag_error($sformatf("x %0d, want %0d", pixel_x, want.x));
          if (pixel_y !== want.y)
            flag_error($sformatf("y %0d, want %0d", pixel_y, want.y));
          if (pixel_color !== want.color)
            flag_error($sformatf("color %0h, want %0h", pixel_color, want.color));
          if (is_last !== want.last)
            flag_error($sformatf("is_last %0b, want %0b", is_last, want.last));
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) begin
        cmd.func  = func;
        cmd.sx    = start_x;
        cmd.sy    = start_y;
        cmd.ex    = end_x;
        cmd.ey    = end_y;
        cmd.color = pen_color;
        trace_line(cmd);
      end
    end
  end

endmodule
